FILE: rtl/pfb_pkg.sv
// Shared types and constants of the page frame store sprite blitter.
package pfb_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 4;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // s_tdata layout, lowest bit first
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_BLIT  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    // Decoded blit of one sprite column byte
    typedef struct packed {
        logic       hit0;   // target page byte exists and is written
        logic       hit1;   // spill into the page below exists and is written
        logic [2:0] page0;
        logic [2:0] page1;
        logic [7:0] col;
        logic [7:0] keep0;
        logic [7:0] bits0;
        logic [7:0] keep1;
        logic [7:0] bits1;
    } t_blit;

endpackage

FILE: rtl/pfb_store.sv
// Single-port frame store memory with registered read data.
module pfb_store #(
    parameter int DEPTH = pfb_pkg::COLUMNS_DEF * pfb_pkg::PAGES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pfb_geom.sv
// Blit decode: bounds rejection, page/column targets, clipping and merge masks.
module pfb_geom #(
    parameter int SCREEN_COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int SCREEN_PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic [7:0]    i_pos_x,
    input  logic [5:0]    i_pos_y,
    input  logic [7:0]    i_sprite_width,
    input  logic [5:0]    i_sprite_height,
    input  logic [6:0]    i_sprite_col,
    input  logic [1:0]    i_sprite_band,
    input  logic [7:0]    i_pixels,
    output pfb_pkg::t_blit o_blit
);
    import pfb_pkg::*;

    logic signed [10:0] sum_x;
    logic signed [10:0] sum_y;
    logic               reject;
    logic               outside;
    logic [2:0]         shift;
    logic signed [4:0]  page0;
    logic signed [4:0]  page1;
    logic signed [9:0]  col;
    logic               col_ok;
    logic               pg0_ok;
    logic               pg1_ok;
    logic               draw;

    always_comb begin
        // x < -w  <=>  x + w < 0, likewise for the far edge and for y
        sum_x = {{3{i_pos_x[7]}}, i_pos_x} + {3'b000, i_sprite_width};
        sum_y = {{5{i_pos_y[5]}}, i_pos_y} + {5'b00000, i_sprite_height};
        reject = (sum_x < 11'sd0) || (sum_x > 11'(SCREEN_COLUMNS))
              || (sum_y < 11'sd0) || (sum_y > 11'(8 * SCREEN_PAGES));
        outside = ({1'b0, i_sprite_col} >= i_sprite_width)
               || ({1'b0, i_sprite_band, 3'b000} >= i_sprite_height);
        draw = !reject && !outside;

        shift = i_pos_y[2:0];
        page0 = {{2{i_pos_y[5]}}, i_pos_y[5:3]} + {3'b000, i_sprite_band};
        page1 = page0 + 5'sd1;
        col   = {{2{i_pos_x[7]}}, i_pos_x} + {3'b000, i_sprite_col};

        col_ok = (col >= 10'sd0) && (col < 10'(SCREEN_COLUMNS));
        pg0_ok = (page0 >= 5'sd0) && (page0 < 5'(SCREEN_PAGES));
        pg1_ok = (page1 >= 5'sd0) && (page1 < 5'(SCREEN_PAGES));

        o_blit.hit0  = draw && col_ok && pg0_ok;
        o_blit.hit1  = draw && col_ok && pg1_ok && (shift != 3'd0);
        o_blit.page0 = page0[2:0];
        o_blit.page1 = page1[2:0];
        o_blit.col   = col[7:0];
        o_blit.keep0 = ~(BYTE_ONES << shift);
        o_blit.bits0 = i_pixels << shift;
        o_blit.keep1 = BYTE_ONES << shift;
        o_blit.bits1 = i_pixels >> (4'd8 - {1'b0, shift});
    end

endmodule

FILE: rtl/page_framebuffer_sprite_blit.sv
// Blit: states RD0, WR0, RD1, WR1, DONE (two read-modify-writes on the single memory port).
// Read: RDS, RDW, DONE; no-op mode: DONE; clear: a pass over every store byte, then DONE.
// One item at a time; the next item is taken once the result is in the output register.
// Synchronous active-low reset runs a clearing pass over every store byte
// (SCREEN_COLUMNS*SCREEN_PAGES bytes) before the first item is accepted.
module page_framebuffer_sprite_blit #(
    parameter int SCREEN_COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int SCREEN_PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x, pos_y, sprite_width, sprite_height, sprite_col, sprite_band, pixels, read_addr
    input  logic [pfb_pkg::IN_TDATA_W-1:0]    s_tdata,
    // mode
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_data, drawn
    output logic [pfb_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import pfb_pkg::*;

    localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_WR0,
        ST_RD1,
        ST_WR1,
        ST_RDS,
        ST_RDW,
        ST_DONE
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr_cnt;
    logic          r_report;
    t_blit         r_blit;
    logic [AW-1:0] r_raddr;
    logic          r_raddr_ok;
    logic [7:0]    r_res_data;
    logic          r_res_drawn;
    logic          r_m_valid;
    logic [8:0]    r_m_data;

    t_blit         blit;
    t_mode         in_mode;
    logic [8:0]    in_raddr;
    logic [11:0]   raddr_ext;
    logic [11:0]   addr0_full;
    logic [11:0]   addr1_full;
    logic          accept;
    logic          res_load;
    logic          mem_en;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    pfb_geom #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES)
    ) u_geom (
        .i_pos_x         (s_tdata[7:0]),
        .i_pos_y         (s_tdata[13:8]),
        .i_sprite_width  (s_tdata[21:14]),
        .i_sprite_height (s_tdata[27:22]),
        .i_sprite_col    (s_tdata[34:28]),
        .i_sprite_band   (s_tdata[36:35]),
        .i_pixels        (s_tdata[44:37]),
        .o_blit          (blit)
    );

    pfb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign in_mode   = t_mode'(s_tuser);
    assign in_raddr  = s_tdata[53:45];
    assign raddr_ext = 12'(in_raddr);
    assign s_tready  = (r_state == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign res_load  = (r_state == ST_DONE) && (!r_m_valid || m_tready);

    assign addr0_full = 12'(r_blit.page0) * 12'(SCREEN_COLUMNS) + 12'(r_blit.col);
    assign addr1_full = 12'(r_blit.page1) * 12'(SCREEN_COLUMNS) + 12'(r_blit.col);

    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = addr0_full[AW-1:0];
        mem_wdata = (mem_rdata & r_blit.keep0) | r_blit.bits0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_clr_cnt;
                mem_wdata = 8'h00;
            end
            ST_RD0: begin
                mem_en = r_blit.hit0;
            end
            ST_WR0: begin
                mem_en = r_blit.hit0;
                mem_we = 1'b1;
            end
            ST_RD1: begin
                mem_en   = r_blit.hit1;
                mem_addr = addr1_full[AW-1:0];
            end
            ST_WR1: begin
                mem_en    = r_blit.hit1;
                mem_we    = 1'b1;
                mem_addr  = addr1_full[AW-1:0];
                mem_wdata = (mem_rdata & r_blit.keep1) | r_blit.bits1;
            end
            ST_RDS: begin
                mem_en   = r_raddr_ok;
                mem_addr = r_raddr;
            end
            ST_IDLE, ST_RDW, ST_DONE: begin
                mem_en = 1'b0;
            end
            default: begin
                mem_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_report  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr_cnt == AW'(DEPTH - 1)) begin
                        r_clr_cnt <= '0;
                        r_state   <= r_report ? ST_DONE : ST_IDLE;
                    end else begin
                        r_clr_cnt <= r_clr_cnt + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_blit      <= blit;
                        r_raddr     <= raddr_ext[AW-1:0];
                        r_raddr_ok  <= (raddr_ext < 12'(DEPTH));
                        r_res_data  <= 8'h00;
                        r_res_drawn <= 1'b0;
                        unique case (in_mode)
                            MODE_CLEAR: begin
                                r_report <= 1'b1;
                                r_state  <= ST_CLEAR;
                            end
                            MODE_BLIT: r_state <= ST_RD0;
                            MODE_READ: r_state <= ST_RDS;
                            MODE_NOP:  r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_RD0: r_state <= ST_WR0;
                ST_WR0: r_state <= ST_RD1;
                ST_RD1: r_state <= ST_WR1;
                ST_WR1: begin
                    r_res_drawn <= r_blit.hit0 || r_blit.hit1;
                    r_state     <= ST_DONE;
                end
                ST_RDS: r_state <= ST_RDW;
                ST_RDW: begin
                    r_res_data <= r_raddr_ok ? mem_rdata : 8'h00;
                    r_state    <= ST_DONE;
                end
                ST_DONE: begin
                    // hold the result until the output register is free
                    if (res_load) begin
                        r_m_data  <= {r_res_drawn, r_res_data};
                        r_report  <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(OUT_TDATA_W - 9){1'b0}}, r_m_data};

endmodule

FILE: dv/page_framebuffer_sprite_blit_tb.sv
// Self-checking testbench of the page frame store sprite blitter, with a frame store predictor.
module page_framebuffer_sprite_blit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfb_pkg::*;

    localparam int COLS        = COLUMNS_DEF;
    localparam int PAGES       = PAGES_DEF;
    localparam int STORE_BYTES = COLS * PAGES;
    localparam int N_ITEMS     = 950;
    localparam int HOLD_AT     = 200;   // result count at which the receiver holds off
    localparam int HOLD_CYCLES = 300;
    localparam int PAUSE_AT    = 450;   // item count at which the sender drains the block
    localparam int STALL_LIMIT = 4000;

    // s_tdata fields, lowest bit last in this list
    typedef struct packed {
        logic [1:0]        pad;
        logic [8:0]        read_addr;
        logic [7:0]        pixels;
        logic [1:0]        sprite_band;
        logic [6:0]        sprite_col;
        logic [5:0]        sprite_height;
        logic [7:0]        sprite_width;
        logic signed [5:0] pos_y;
        logic signed [7:0] pos_x;
    } blit_cmd_t;

    typedef struct packed {
        logic [6:0] pad;
        logic       drawn;
        logic [7:0] read_data;
    } store_result_t;

    class frame_store_scoreboard;
        logic [7:0]    store[STORE_BYTES];
        store_result_t expected_q[$];
        int            errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (store[i]) store[i] = 8'h00;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit merge(int page, int col, logic [7:0] keep, logic [7:0] bits);
            if (page < 0 || page >= PAGES || col < 0 || col >= COLS)
                return 1'b0;
            store[page*COLS + col] = (store[page*COLS + col] & keep) | bits;
            return 1'b1;
        endfunction

        function bit blit(blit_cmd_t c);
            int         x, y, w, h, scol, band, shift, page, col;
            logic [7:0] pix, keep0, bits0, keep1, bits1;
            bit         hit;
            x    = $signed(c.pos_x);
            y    = $signed(c.pos_y);
            w    = c.sprite_width;
            h    = c.sprite_height;
            scol = c.sprite_col;
            band = c.sprite_band;
            pix  = c.pixels;
            if (x < -w || x > COLS - w || y < -h || y > 8*PAGES - h)
                return 1'b0;
            if (scol >= w || band*8 >= h)
                return 1'b0;
            shift = y & 7;
            page  = (y - shift) / 8 + band;
            col   = x + scol;
            keep0 = ~(BYTE_ONES << shift);
            bits0 = pix << shift;
            keep1 = BYTE_ONES << shift;
            bits1 = pix >> (8 - shift);
            hit = merge(page, col, keep0, bits0);
            // spill of the low rows into the page below
            if (shift != 0 && merge(page + 1, col, keep1, bits1))
                hit = 1'b1;
            return hit;
        endfunction

        function void note_item(t_mode m, blit_cmd_t c);
            store_result_t r;
            r = '0;
            case (m)
                MODE_CLEAR: wipe();
                MODE_BLIT:  r.drawn = blit(c);
                MODE_READ: begin
                    if (c.read_addr < STORE_BYTES)
                        r.read_data = store[c.read_addr];
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            if (errors < 40)
                $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] raw);
            store_result_t got, want;
            got = raw;
            if (expected_q.size() == 0) begin
                report("unexpected result", got.read_data, 8'h00);
                return;
            end
            want = expected_q.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.drawn !== want.drawn)
                report("drawn", {7'd0, got.drawn}, {7'd0, want.drawn});
        endtask
    endclass

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // pos_x, pos_y, sprite_width, sprite_height,
                                             // sprite_col, sprite_band, pixels, read_addr
    logic [1:0]             s_tuser  = MODE_NOP; // mode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // read_data, drawn

    frame_store_scoreboard sb;
    int n_sent      = 0;
    int n_results   = 0;
    int stall_count = 0;
    bit sender_idle = 1'b1;

    page_framebuffer_sprite_blit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic blit_cmd_t random_cmd();
        blit_cmd_t c;
        c = 56'({$urandom(), $urandom()});
        c.pad = '0;
        return c;
    endfunction

    // valid stays high between back-to-back items; it only drops for a gap or in go_quiet
    task automatic send_item(input t_mode m, input blit_cmd_t c);
        int gap;
        gap = sender_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= c;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_item(m, c);
        n_sent++;
        sender_idle = ((n_sent / 100) % 3) != 2;
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic blit_item(int x, int y, int w, int h, int col, int band, int pix);
        blit_cmd_t c;
        c = random_cmd();
        c.pos_x         = 8'(x);
        c.pos_y         = 6'(y);
        c.sprite_width  = 8'(w);
        c.sprite_height = 6'(h);
        c.sprite_col    = 7'(col);
        c.sprite_band   = 2'(band);
        c.pixels        = 8'(pix);
        send_item(MODE_BLIT, c);
    endtask

    task automatic read_item(int addr);
        blit_cmd_t c;
        c = random_cmd();
        c.read_addr = 9'(addr);
        send_item(MODE_READ, c);
    endtask

    // one well-formed sprite: bands of up to 8 columns, rare stray blits, then reads around it
    task automatic draw_sprite();
        int w, h, x, y, nb, ncol, col, page, k;
        w    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
        h    = $urandom_range(1, 32);
        x    = int'($urandom_range(0, 128)) - w;
        y    = int'($urandom_range(0, 32)) - h;
        nb   = (h + 7) / 8;
        ncol = (w > 8) ? 8 : w;
        for (int c = 0; c < ncol; c++) begin
            col = (w > 8) ? $urandom_range(0, w - 1) : c;
            for (int b = 0; b < nb; b++) begin
                if ($urandom_range(0, 19) == 0)
                    blit_item(x, y, w, h, $urandom_range(0, 127), $urandom_range(0, 3),
                              $urandom);
                else
                    blit_item(x, y, w, h, col, b, $urandom);
            end
        end
        repeat ($urandom_range(1, 4)) begin
            page = (y >= 0 ? y / 8 : -1) + int'($urandom_range(0, nb));
            k    = x + int'($urandom_range(0, ncol));
            page = (page < 0) ? 0 : (page >= PAGES ? PAGES - 1 : page);
            k    = (k < 0) ? 0 : (k >= COLS ? COLS - 1 : k);
            read_item(page*COLS + k);
        end
    endtask

    task automatic plain_item(t_mode m);
        send_item(m, random_cmd());
    endtask

    // receiver: random back-pressure, one long hold-off so the block backs up
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            if (n_results == HOLD_AT)
                gap = HOLD_CYCLES;
            else if (((n_results / 80) % 3) == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            sb.check_result(m_tdata);
            n_results++;
        end
    end

    initial begin
        int r;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        read_item(0);
        read_item(STORE_BYTES - 1);
        blit_item(0, 0, 8, 8, 0, 0, 8'hFF);
        read_item(0);
        blit_item(127, 3, 1, 8, 0, 0, 8'hA5);       // spill into the page below
        read_item(127);
        read_item(COLS + 127);
        blit_item(-3, 0, 4, 8, 0, 0, 8'hFF);        // column left of the screen
        blit_item(-3, 0, 4, 8, 3, 0, 8'h3C);
        blit_item(-128, -32, 128, 32, 127, 3, 8'hFF);
        blit_item(-5, -5, 8, 8, 5, 0, 8'hFF);       // target page above the screen
        blit_item(127, 31, 1, 1, 0, 0, 8'hFF);      // spill below the last page
        read_item(3*COLS + 127);
        blit_item(121, 0, 8, 8, 0, 0, 8'hFF);       // rejected: right edge
        blit_item(0, -32, 8, 1, 0, 0, 8'hFF);       // rejected: above the top
        blit_item(10, 8, 4, 8, 4, 0, 8'hFF);        // column outside the sprite
        blit_item(10, 8, 4, 8, 0, 1, 8'hFF);        // band outside the sprite
        blit_item(10, 8, 0, 8, 0, 0, 8'hFF);        // zero width
        blit_item(10, 8, 4, 0, 0, 0, 8'hFF);        // zero height
        blit_item(0, 0, 255, 63, 127, 3, 8'h00);
        plain_item(MODE_NOP);
        plain_item(MODE_CLEAR);
        read_item(0);
        read_item(COLS + 127);

        while (n_sent < N_ITEMS) begin
            if (n_sent >= PAUSE_AT && n_sent < PAUSE_AT + 40) begin
                go_quiet();
                while (sb.pending() != 0) @(posedge i_clk);
                draw_sprite();
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                draw_sprite();
            else if (r < 82)
                read_item($urandom_range(0, STORE_BYTES - 1));
            else if (r < 84)
                plain_item(MODE_CLEAR);
            else if (r < 87)
                plain_item(MODE_NOP);
            else
                plain_item(MODE_BLIT);
        end

        go_quiet();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
